FILE: src/gfsu_pkg.sv
// Shared types, constants and GF(2^8) helper functions for the field and S-box unit.
package gfsu_pkg;

	// Operation codes
	localparam logic [1:0] OpMul     = 2'd0;
	localparam logic [1:0] OpInv     = 2'd1;
	localparam logic [1:0] OpSbox    = 2'd2;
	localparam logic [1:0] OpInvSbox = 2'd3;

	// Configuration register indexes
	localparam logic CfgPoly   = 1'b0;
	localparam logic CfgAffine = 1'b1;

	// Reset values and fallback polynomial
	localparam logic [8:0] PolyFallback = 9'h12B;
	localparam logic [7:0] AffineReset  = 8'h63;

	// Square-and-multiply steps for a^254 (a^2 * a^4 * ... * a^128)
	localparam int InvSteps = 7;

	// All irreducible polynomials of degree 1 to 4; a reducible degree-8 polynomial has one as a factor
	localparam int NumFactors = 8;
	localparam logic [8:0] FactorPoly [NumFactors] = '{
		9'h002, 9'h003, 9'h007, 9'h00B, 9'h00D, 9'h013, 9'h019, 9'h01F
	};
	localparam int FactorDeg [NumFactors] = '{1, 1, 2, 3, 3, 4, 4, 4};

	// One item in the exponentiation chain
	typedef struct packed {
		logic [1:0] op;
		logic       done;   // multiply already applied, pass acc through
		logic [7:0] acc;
		logic [7:0] sq;
	} gfsu_item_t;

	// Product modulo x^8 + red
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] red);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = {x[6:0], 1'b0} ^ (x[7] ? red : 8'h00);
		end
		return acc;
	endfunction

	// Low byte of the polynomial actually used; bit 8 is implied
	function automatic logic [7:0] eff_poly_low(input logic [8:0] p);
		logic [8:0] rem;
		logic       ok;
		ok = p[8];
		for (int f = 0; f < NumFactors; f++) begin
			rem = p;
			for (int bi = 8; bi >= 1; bi--) begin
				if (bi >= FactorDeg[f] && rem[bi]) begin
					rem = rem ^ (FactorPoly[f] << (bi - FactorDeg[f]));
				end
			end
			if (rem == 9'd0) begin
				ok = 1'b0;
			end
		end
		return ok ? p[7:0] : PolyFallback[7:0];
	endfunction

	// Forward affine map: t ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ c
	function automatic logic [7:0] affine_fwd(input logic [7:0] t, input logic [7:0] c);
		return t ^ {t[6:0], t[7]} ^ {t[5:0], t[7:6]} ^ {t[4:0], t[7:5]}
			^ {t[3:0], t[7:4]} ^ c;
	endfunction

	// Inverse affine map: u = s ^ c, then rotl1 ^ rotl3 ^ rotl6
	function automatic logic [7:0] affine_inv(input logic [7:0] s, input logic [7:0] c);
		logic [7:0] u;
		u = s ^ c;
		return {u[6:0], u[7]} ^ {u[4:0], u[7:5]} ^ {u[1:0], u[7:2]};
	endfunction

endpackage

FILE: src/gfsu_step.sv
// One registered square-and-multiply step of the exponentiation chain.
module gfsu_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           red,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gfsu_pkg::gfsu_item_t in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gfsu_pkg::gfsu_item_t out_item
);

	logic                 valid_s1;
	gfsu_pkg::gfsu_item_t item_s1;
	gfsu_pkg::gfsu_item_t next_item;

	// acc *= sq and sq = sq^2 in parallel; finished multiplies pass through
	always_comb begin
		next_item = in_item;
		if (!in_item.done) begin
			next_item.acc  = gfsu_pkg::gf_mul(in_item.acc, in_item.sq, red);
			next_item.sq   = gfsu_pkg::gf_mul(in_item.sq, in_item.sq, red);
			next_item.done = (in_item.op == gfsu_pkg::OpMul);
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= next_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

FILE: src/gf256_field_and_sbox_unit.sv
// Top level: pipelined GF(2^8) multiply, inverse, S-box and inverse S-box unit.
// Pipeline: ten register stages from input transaction to result (input
// prep, squaring, seven square-and-multiply stages, output with the affine map).
// Throughput: one transaction per cycle; each stage holds one item and stalls
// only when the stage after it is full.
// Reset: all stage valid bits clear, the polynomial returns to 0x12B and the
// affine constant to 0x63.
module gf256_field_and_sbox_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] operand_a, [15:8] operand_b
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] result
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int N = gfsu_pkg::InvSteps;

	logic [7:0] eff_poly_q;
	logic [7:0] affine_q;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] x_s1;
	logic [7:0] b_s1;
	logic       s1_ready;

	logic                 valid_s2;
	gfsu_pkg::gfsu_item_t item_s2;
	gfsu_pkg::gfsu_item_t s2_next;
	logic                 s2_ready;

	logic                 chain_valid [N+1];
	logic                 chain_ready [N+1];
	gfsu_pkg::gfsu_item_t chain_item  [N+1];

	logic       out_valid_q;
	logic [7:0] result_q;
	logic       out_ready;
	logic [7:0] final_result;

	// Configuration registers; polynomial is checked once on write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_poly_q <= gfsu_pkg::PolyFallback[7:0];
			affine_q   <= gfsu_pkg::AffineReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gfsu_pkg::CfgPoly:   eff_poly_q <= gfsu_pkg::eff_poly_low(cfg_data);
				gfsu_pkg::CfgAffine: affine_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1: inverse affine map for the inverse S-box
	assign s1_ready = !valid_s1 || s2_ready;
	assign s_tready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && s_tvalid) begin
			op_s1 <= s_tuser;
			b_s1  <= s_tdata[15:8];
			x_s1  <= (s_tuser == gfsu_pkg::OpInvSbox)
				? gfsu_pkg::affine_inv(s_tdata[7:0], affine_q) : s_tdata[7:0];
		end
	end

	// Stage 2: seed the chain (a,b for multiply; acc=1, sq=x^2 otherwise)
	always_comb begin
		s2_next.op   = op_s1;
		s2_next.done = 1'b0;
		if (op_s1 == gfsu_pkg::OpMul) begin
			s2_next.acc = x_s1;
			s2_next.sq  = b_s1;
		end else begin
			s2_next.acc = 8'h01;
			s2_next.sq  = gfsu_pkg::gf_mul(x_s1, x_s1, eff_poly_q);
		end
	end

	assign s2_ready = !valid_s2 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			item_s2 <= s2_next;
		end
	end

	assign chain_valid[0] = valid_s2;
	assign chain_item[0]  = item_s2;

	// Square-and-multiply stages
	for (genvar k = 0; k < N; k++) begin : g_step
		gfsu_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.red       (eff_poly_q),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_item   (chain_item[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	// Output stage: forward affine map for the S-box
	assign final_result = (chain_item[N].op == gfsu_pkg::OpSbox)
		? gfsu_pkg::affine_fwd(chain_item[N].acc, affine_q) : chain_item[N].acc;

	assign out_ready      = !out_valid_q || m_tready;
	assign chain_ready[N] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= chain_valid[N];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && chain_valid[N]) begin
			result_q <= final_result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	// Any usable polynomial has a nonzero constant term
	a_poly_const: assert property (@(posedge clk) disable iff (!arst_n)
		eff_poly_q[0])
		else $error("effective polynomial has x as a factor");

	// A stalled first stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_ready |=> valid_s1 && $stable(op_s1) && $stable(x_s1))
		else $error("stage 1 item lost under stall");

	// A multiply has been applied exactly once by the end of the chain
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[N] && chain_item[N].op == gfsu_pkg::OpMul |-> chain_item[N].done)
		else $error("multiply not applied in chain");

	// Input backpressure only when the output is blocked
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the GF(2^8) field and S-box unit.
module tb_top;

	localparam int PipeDepth = 11;
	localparam int IdleLimit = 3000;
	localparam int PhaseItems = 150;
	localparam logic [8:0] LowDegreeDivisors [8] = '{
		9'h002, 9'h003, 9'h007, 9'h00B, 9'h00D, 9'h013, 9'h019, 9'h01F
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data = '0;

	// Predictor copy of the two registers
	logic [8:0]  model_poly = gfsu_pkg::PolyFallback;
	logic [7:0]  model_affine = gfsu_pkg::AffineReset;

	logic [7:0]  awaited_bytes [$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          quiet_mode = 1'b0;
	int          hold_request = 0;

	gf256_field_and_sbox_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// Remainder of a polynomial over GF(2) after division by a small divisor
	function automatic logic [8:0] poly_remainder(input logic [8:0] num,
			input logic [8:0] div);
		logic [8:0] r;
		int         deg;
		r = num;
		deg = 0;
		for (int i = 0; i < 9; i++) begin
			if (div[i]) begin
				deg = i;
			end
		end
		for (int k = 8; k >= deg; k--) begin
			if (r[k]) begin
				r = r ^ (div << (k - deg));
			end
		end
		return r;
	endfunction

	// Degree 8 and no factor of degree 1 to 4
	function automatic bit poly_usable(input logic [8:0] p);
		if (!p[8]) begin
			return 1'b0;
		end
		for (int i = 0; i < 8; i++) begin
			if (poly_remainder(p, LowDegreeDivisors[i]) == 9'd0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] field_reducer(input logic [8:0] p);
		return poly_usable(p) ? p[7:0] : gfsu_pkg::PolyFallback[7:0];
	endfunction

	// Shift-and-add product, reducing by x^8 = red
	function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] red);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc ^= x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ red) : {x[6:0], 1'b0};
		end
		return acc;
	endfunction

	// a^254 by binary exponentiation; zero stays zero
	function automatic logic [7:0] field_inverse(input logic [7:0] a, input logic [7:0] red);
		logic [7:0] acc;
		logic [7:0] base;
		logic [7:0] e;
		acc = 8'h01;
		base = a;
		e = 8'd254;
		while (e != 0) begin
			if (e[0]) begin
				acc = field_product(acc, base, red);
			end
			base = field_product(base, base, red);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic [7:0] rot_left(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] field_op_result(input logic [1:0] op, input logic [7:0] a,
			input logic [7:0] b);
		logic [7:0] red;
		logic [7:0] t;
		red = field_reducer(model_poly);
		case (op)
			gfsu_pkg::OpMul: begin
				return field_product(a, b, red);
			end
			gfsu_pkg::OpInv: begin
				return field_inverse(a, red);
			end
			gfsu_pkg::OpSbox: begin
				t = field_inverse(a, red);
				return t ^ rot_left(t, 1) ^ rot_left(t, 2) ^ rot_left(t, 3)
					^ rot_left(t, 4) ^ model_affine;
			end
			default: begin
				t = a ^ model_affine;
				t = rot_left(t, 1) ^ rot_left(t, 3) ^ rot_left(t, 6);
				return field_inverse(t, red);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- helpers

	// Mostly short gaps, a few long ones; none in quiet mode
	function automatic int gap_length();
		int r;
		if (quiet_mode) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Random byte with extra weight on the edge values
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h80;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [8:0] draw_usable_poly();
		logic [8:0] p;
		do begin
			p = {1'b1, 8'($urandom)};
		end while (!poly_usable(p));
		return p;
	endfunction

	// Offer one item; the expectation is queued at the accepting edge
	task automatic send_item(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		do @(posedge clk); while (!s_tready);
		awaited_bytes.push_back(field_op_result(op, a, b));
	endtask

	task automatic send_random_item();
		send_item(2'($urandom), pick_byte(), pick_byte());
	endtask

	// Stop offering, collect every result, then let the pipeline empty
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (awaited_bytes.size() != 0) @(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == gfsu_pkg::CfgPoly) begin
			model_poly = value;
		end else begin
			model_affine = value[7:0];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	// Reset settings: edge operands, every operation, zero inverse, ignored operand_b
	task automatic test_directed_cases();
		send_item(gfsu_pkg::OpMul, 8'h00, 8'hFF);
		send_item(gfsu_pkg::OpMul, 8'hFF, 8'hFF);
		send_item(gfsu_pkg::OpMul, 8'h01, 8'hA5);
		send_item(gfsu_pkg::OpMul, 8'h80, 8'h02);
		send_item(gfsu_pkg::OpMul, 8'hFF, 8'h00);
		send_item(gfsu_pkg::OpInv, 8'h00, 8'h00);
		send_item(gfsu_pkg::OpInv, 8'h00, 8'hFF);
		send_item(gfsu_pkg::OpInv, 8'h01, 8'h00);
		send_item(gfsu_pkg::OpInv, 8'hFF, 8'h5A);
		send_item(gfsu_pkg::OpInv, 8'h80, 8'hFF);
		send_item(gfsu_pkg::OpSbox, 8'h00, 8'h00);
		send_item(gfsu_pkg::OpSbox, 8'h00, 8'hFF);
		send_item(gfsu_pkg::OpSbox, 8'hFF, 8'hAA);
		send_item(gfsu_pkg::OpSbox, 8'h01, 8'h00);
		send_item(gfsu_pkg::OpInvSbox, 8'h63, 8'h00);
		send_item(gfsu_pkg::OpInvSbox, 8'h63, 8'hFF);
		send_item(gfsu_pkg::OpInvSbox, 8'h00, 8'h00);
		send_item(gfsu_pkg::OpInvSbox, 8'hFF, 8'h55);
		send_item(gfsu_pkg::OpInvSbox, 8'h7C, 8'h00);
		send_item(gfsu_pkg::OpMul, 8'h53, 8'hCA);
		drain_pipeline();
	endtask

	// Usable and unusable polynomials, with the affine constant at its extremes
	task automatic test_polynomial_fallback();
		logic [8:0] polys [6];
		polys = '{9'h11B, 9'h0FF, 9'h000, 9'h100, 9'h1FF, 9'h12B};
		for (int s = 0; s < 6; s++) begin
			write_register(gfsu_pkg::CfgPoly, polys[s]);
			write_register(gfsu_pkg::CfgAffine, s[0] ? 9'h1FF : 9'h000);
			for (int i = 0; i < 10; i++) begin
				send_random_item();
			end
			drain_pipeline();
		end
	endtask

	// Long receiver hold-off while the sender keeps offering back to back
	task automatic test_backpressure();
		write_register(gfsu_pkg::CfgPoly, draw_usable_poly());
		write_register(gfsu_pkg::CfgAffine, 9'($urandom));
		quiet_mode = 1'b1;
		hold_request = 300;
		for (int i = 0; i < 80; i++) begin
			send_random_item();
		end
		quiet_mode = 1'b0;
		drain_pipeline();
	endtask

	// Random settings per phase, one phase without any gaps
	task automatic test_random_phases();
		logic [8:0] poly;
		logic [8:0] affine;
		for (int ph = 0; ph < 8; ph++) begin
			poly = ($urandom_range(0, 3) == 0) ? 9'($urandom) : draw_usable_poly();
			affine = (ph == 0) ? 9'h000 : (ph == 1) ? 9'h0FF : 9'($urandom);
			write_register(gfsu_pkg::CfgPoly, poly);
			write_register(gfsu_pkg::CfgAffine, affine);
			quiet_mode = (ph == 3);
			for (int i = 0; i < PhaseItems; i++) begin
				send_random_item();
			end
			quiet_mode = 1'b0;
			drain_pipeline();
		end
	endtask

	// ---------------------------------------------------------------- sink and checks

	// Result side ready: random stalls, plus the long hold-off on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_request > 0) begin
				m_tready <= 1'b0;
				stall_left = hold_request - 1;
				hold_request = 0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = gap_length();
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_bytes.size() == 0) begin
				fail_count++;
				$error("result: expected none, actual %02h", m_tdata);
			end else begin
				want = awaited_bytes.pop_front();
				if (m_tdata !== want) begin
					fail_count++;
					$error("result: expected %02h, actual %02h", want, m_tdata);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IdleLimit) begin
				$display("tb_top failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_polynomial_fallback();
		test_backpressure();
		test_random_phases();
		s_tvalid <= 1'b0;
		while (awaited_bytes.size() != 0) @(posedge clk);
		repeat (PipeDepth + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
